// ===== rtl/core/spread_spectrum_despread_detector_macros.svh =====
// assertion helpers for the despread detector
`ifndef SPREAD_SPECTRUM_DESPREAD_DETECTOR_MACROS_SVH
`define SPREAD_SPECTRUM_DESPREAD_DETECTOR_MACROS_SVH
`ifndef SYNTHESIS
`define SPSD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define SPSD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SPSD_ASSERT(label, clk, rst, prop)
`define SPSD_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/core/spsd_pkg.sv =====
package spsd_pkg;

  localparam int PIX_W        = 8;
  localparam int MAX_CH       = 4;
  localparam int DIFF_W       = 11;
  localparam int DIFF_MAX     = 1020;
  localparam int LCG_W        = 32;
  localparam int POS_W        = 5;
  localparam int CHAN_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam int BIT_NUM_W    = 5;
  localparam int BIT_CORR_W   = 17;
  localparam int CORR_TOTAL_W = 22;
  localparam int SQ_TOTAL_W   = 37;
  localparam int ABS_TOTAL_W  = 21;

  localparam logic [CFG_IDX_W-1:0] REG_SEED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LCG_MULT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LCG_ADD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHIP_POS = 3'd4;

  localparam logic [LCG_W-1:0]  SEED_RST     = 32'd0;
  localparam logic [CHAN_W-1:0] CHANNELS_RST = 3'd3;
  localparam logic [LCG_W-1:0]  LCG_MULT_RST = 32'd1664525;
  localparam logic [LCG_W-1:0]  LCG_ADD_RST  = 32'd1013904223;
  localparam logic [POS_W-1:0]  CHIP_POS_RST = 5'd31;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

// ===== rtl/core/spsd_intf.sv =====
interface spsd_pix_if;
  logic            valid;
  logic            ready;
  spsd_pkg::pix_t  a_ch0;
  spsd_pkg::pix_t  a_ch1;
  spsd_pkg::pix_t  a_ch2;
  spsd_pkg::pix_t  a_ch3;
  spsd_pkg::pix_t  b_ch0;
  spsd_pkg::pix_t  b_ch1;
  spsd_pkg::pix_t  b_ch2;
  spsd_pkg::pix_t  b_ch3;

  modport source (
    output valid, a_ch0, a_ch1, a_ch2, a_ch3, b_ch0, b_ch1, b_ch2, b_ch3,
    input  ready
  );
  modport sink (
    input  valid, a_ch0, a_ch1, a_ch2, a_ch3, b_ch0, b_ch1, b_ch2, b_ch3,
    output ready
  );
endinterface

interface spsd_res_if;
  logic                                      valid;
  logic                                      ready;
  logic        [spsd_pkg::BIT_NUM_W-1:0]     bit_number;
  logic signed [spsd_pkg::BIT_CORR_W-1:0]    bit_corr;
  logic                                      bit_value;
  logic                                      final_bit;
  logic signed [spsd_pkg::CORR_TOTAL_W-1:0]  corr_total;
  logic        [spsd_pkg::SQ_TOTAL_W-1:0]    corr_sq_total;
  logic        [spsd_pkg::ABS_TOTAL_W-1:0]   abs_total;
  logic                                      suspicious;

  modport source (
    output valid, bit_number, bit_corr, bit_value, final_bit, corr_total,
           corr_sq_total, abs_total, suspicious,
    input  ready
  );
  modport sink (
    input  valid, bit_number, bit_corr, bit_value, final_bit, corr_total,
           corr_sq_total, abs_total, suspicious,
    output ready
  );
endinterface

// ===== rtl/core/spread_spectrum_despread_detector.sv =====
// Despreading correlator for a spread-spectrum header hidden in pixel pairs.
// pix: one word per chip, the channels of pixel A and pixel B in permuted
//   order; only the first channel_count (0 as 1, max MAX_CH) channels are summed.
// res: one word per completed header bit (every CHIP_LEN pix words); the
//   word for the last header bit also carries the totals and the verdict.
// cfg: write enable, register index and data; the user must let registers change
//   only while idle; the block does not enforce it. A seed write restarts the generator and clears counts.
// Throughput: one pix word per cycle while pix.ready is high. The generator step
//   (a 32x32 multiply feeding its own state register) is the loop that sets that figure.
// Result path: the last pix word of a bit goes through the diff/chip stage and
//   the accumulate, square and output registers; a stall can hold each of them.
// Reset: registers go to their defaults, the generator to seed 0, all
//   counters and sums to zero; no word is pending.
// Stall: three result stages buffer finished bits, so pix words keep being
//   taken while a res word waits; ready drops only when a finished bit has
//   no free stage to move into.
`include "spread_spectrum_despread_detector_macros.svh"

module spread_spectrum_despread_detector #(
  parameter int CHIP_LEN   = 64,
  parameter int HEADER_LEN = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [spsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  spsd_pix_if.sink                           pix,
  spsd_res_if.source                         res
);

  localparam int CW       = (CHIP_LEN > 1) ? $clog2(CHIP_LEN) : 1;
  localparam int BW       = (HEADER_LEN > 1) ? $clog2(HEADER_LEN) : 1;
  localparam int HW       = $clog2(HEADER_LEN);
  localparam int CORR_MAX = CHIP_LEN * spsd_pkg::DIFF_MAX;
  localparam int CORR_W   = $clog2(CORR_MAX + 1) + 1;
  localparam int ABS_W    = CORR_W - 1;
  localparam int SQ_W     = 2 * ABS_W;
  localparam int SUM_W    = CORR_W + HW;
  localparam int ABST_W   = ABS_W + HW;
  localparam int SQT_W    = SQ_W + HW;
  localparam int THR      = CHIP_LEN * HEADER_LEN;
  localparam int CMP_W    = ABST_W + $clog2(THR * spsd_pkg::MAX_CH + 1) + 1;
  localparam int SUMIN_W  = spsd_pkg::PIX_W + 2;

  // configuration registers
  logic [spsd_pkg::LCG_W-1:0]  seed;
  logic [spsd_pkg::CHAN_W-1:0] channel_count;
  logic [spsd_pkg::LCG_W-1:0]  lcg_mult;
  logic [spsd_pkg::LCG_W-1:0]  lcg_add;
  logic [spsd_pkg::POS_W-1:0]  chip_bit_pos;
  logic [spsd_pkg::CHAN_W-1:0] eff;

  // accept side
  logic [spsd_pkg::LCG_W-1:0]        lcg_state;
  logic [spsd_pkg::LCG_W-1:0]        lcg_next;
  logic [CW-1:0]                     chip_cnt;
  logic [BW-1:0]                     bit_cnt;
  logic                              done0;
  logic                              last0;
  logic                              pix_fire;
  logic [SUMIN_W-1:0]                a_sum;
  logic [SUMIN_W-1:0]                b_sum;
  logic signed [spsd_pkg::DIFF_W-1:0] diff0;

  // chip stage
  logic                               v1;
  logic signed [spsd_pkg::DIFF_W-1:0] d1;
  logic                               chip1;
  logic                               done1;
  logic                               last1;
  logic [spsd_pkg::BIT_NUM_W-1:0]     num1;
  logic signed [CORR_W-1:0]           bit_acc;
  logic signed [CORR_W-1:0]           dx;
  logic signed [CORR_W-1:0]           acc_next;

  // correlation stage
  logic                           r1v;
  logic signed [CORR_W-1:0]       r1_corr;
  logic                           r1_last;
  logic [spsd_pkg::BIT_NUM_W-1:0] r1_num;
  logic [ABS_W-1:0]               abs1;
  logic [SQ_W-1:0]                sq1;

  // square stage
  logic                           r2v;
  logic signed [CORR_W-1:0]       r2_corr;
  logic [ABS_W-1:0]               r2_abs;
  logic [SQ_W-1:0]                r2_sq;
  logic                           r2_last;
  logic [spsd_pkg::BIT_NUM_W-1:0] r2_num;

  // totals and output word
  logic signed [SUM_W-1:0] sum_acc;
  logic [ABST_W-1:0]       abs_acc;
  logic [SQT_W-1:0]        sq_acc;
  logic signed [SUM_W-1:0] sum_next;
  logic [ABST_W-1:0]       abs_next;
  logic [SQT_W-1:0]        sq_next;
  logic                    susp_next;

  logic                                      ov;
  logic [spsd_pkg::BIT_NUM_W-1:0]            o_num;
  logic signed [spsd_pkg::BIT_CORR_W-1:0]    o_corr;
  logic                                      o_value;
  logic                                      o_final;
  logic signed [spsd_pkg::CORR_TOTAL_W-1:0]  o_total;
  logic [spsd_pkg::SQ_TOTAL_W-1:0]           o_sq;
  logic [spsd_pkg::ABS_TOTAL_W-1:0]          o_abs;
  logic                                      o_susp;

  // flow control
  logic o_free;
  logic r2_free;
  logic r1_free;
  logic s1_go;
  logic s1_fire;
  logic r1_load;
  logic r2_load;
  logic o_load;
  logic seed_wr;

  assign o_free  = !ov || res.ready;
  assign r2_free = !r2v || o_free;
  assign r1_free = !r1v || r2_free;
  assign s1_go   = !done1 || r1_free;
  assign s1_fire = v1 && s1_go;
  assign r1_load = s1_fire && done1;
  assign r2_load = r1v && r2_free;
  assign o_load  = r2v && o_free;

  assign pix.ready = !v1 || s1_go;
  assign pix_fire  = pix.valid && pix.ready;
  assign seed_wr   = cfg_write && (cfg_index == spsd_pkg::REG_SEED);

  always_comb begin
    if (channel_count == '0) begin
      eff = 3'd1;
    end else if (channel_count > 3'(spsd_pkg::MAX_CH)) begin
      eff = 3'(spsd_pkg::MAX_CH);
    end else begin
      eff = channel_count;
    end
  end

  // luminance difference over the used channels
  always_comb begin
    a_sum = SUMIN_W'(pix.a_ch0);
    b_sum = SUMIN_W'(pix.b_ch0);
    if (eff >= 3'd2) begin
      a_sum = a_sum + SUMIN_W'(pix.a_ch1);
      b_sum = b_sum + SUMIN_W'(pix.b_ch1);
    end
    if (eff >= 3'd3) begin
      a_sum = a_sum + SUMIN_W'(pix.a_ch2);
      b_sum = b_sum + SUMIN_W'(pix.b_ch2);
    end
    if (eff >= 3'd4) begin
      a_sum = a_sum + SUMIN_W'(pix.a_ch3);
      b_sum = b_sum + SUMIN_W'(pix.b_ch3);
    end
  end

  assign diff0    = $signed({1'b0, a_sum}) - $signed({1'b0, b_sum});
  assign lcg_next = lcg_state * lcg_mult + lcg_add;
  assign done0    = (chip_cnt == CW'(CHIP_LEN - 1));
  assign last0    = done0 && (bit_cnt == BW'(HEADER_LEN - 1));

  assign dx       = CORR_W'(d1);
  assign acc_next = chip1 ? (bit_acc + dx) : (bit_acc - dx);

  assign abs1 = r1_corr[CORR_W-1] ? ABS_W'(-r1_corr) : ABS_W'(r1_corr);
  assign sq1  = abs1 * abs1;

  assign sum_next  = sum_acc + SUM_W'(r2_corr);
  assign abs_next  = abs_acc + ABST_W'(r2_abs);
  assign sq_next   = sq_acc + SQT_W'(r2_sq);
  assign susp_next = CMP_W'({abs_next, 1'b0}) > (CMP_W'(THR) * CMP_W'(eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      seed          <= spsd_pkg::SEED_RST;
      channel_count <= spsd_pkg::CHANNELS_RST;
      lcg_mult      <= spsd_pkg::LCG_MULT_RST;
      lcg_add       <= spsd_pkg::LCG_ADD_RST;
      chip_bit_pos  <= spsd_pkg::CHIP_POS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spsd_pkg::REG_SEED:     seed          <= cfg_data;
        spsd_pkg::REG_CHANNELS: channel_count <= cfg_data[spsd_pkg::CHAN_W-1:0];
        spsd_pkg::REG_LCG_MULT: lcg_mult      <= cfg_data;
        spsd_pkg::REG_LCG_ADD:  lcg_add       <= cfg_data;
        spsd_pkg::REG_CHIP_POS: chip_bit_pos  <= cfg_data[spsd_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= spsd_pkg::SEED_RST;
      chip_cnt  <= '0;
      bit_cnt   <= '0;
      bit_acc   <= '0;
      sum_acc   <= '0;
      abs_acc   <= '0;
      sq_acc    <= '0;
      v1        <= 1'b0;
      r1v       <= 1'b0;
      r2v       <= 1'b0;
      ov        <= 1'b0;
    end else if (seed_wr) begin
      lcg_state <= cfg_data;
      chip_cnt  <= '0;
      bit_cnt   <= '0;
      bit_acc   <= '0;
      sum_acc   <= '0;
      abs_acc   <= '0;
      sq_acc    <= '0;
    end else begin
      if (pix_fire) begin
        if (last0) begin
          // header complete: restart the generator from the seed
          lcg_state <= seed;
          chip_cnt  <= '0;
          bit_cnt   <= '0;
        end else if (done0) begin
          lcg_state <= lcg_next;
          chip_cnt  <= '0;
          bit_cnt   <= bit_cnt + 1'b1;
        end else begin
          lcg_state <= lcg_next;
          chip_cnt  <= chip_cnt + 1'b1;
        end
      end

      if (s1_fire) begin
        bit_acc <= done1 ? '0 : acc_next;
      end

      if (o_load) begin
        if (r2_last) begin
          sum_acc <= '0;
          abs_acc <= '0;
          sq_acc  <= '0;
        end else begin
          sum_acc <= sum_next;
          abs_acc <= abs_next;
          sq_acc  <= sq_next;
        end
      end

      if (pix_fire) begin
        v1 <= 1'b1;
      end else if (s1_fire) begin
        v1 <= 1'b0;
      end

      if (r1_load) begin
        r1v <= 1'b1;
      end else if (r2_load) begin
        r1v <= 1'b0;
      end

      if (r2_load) begin
        r2v <= 1'b1;
      end else if (o_load) begin
        r2v <= 1'b0;
      end

      if (o_load) begin
        ov <= 1'b1;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      d1    <= diff0;
      chip1 <= lcg_next[chip_bit_pos];
      done1 <= done0;
      last1 <= last0;
      num1  <= spsd_pkg::BIT_NUM_W'(bit_cnt);
    end
    if (r1_load) begin
      r1_corr <= acc_next;
      r1_last <= last1;
      r1_num  <= num1;
    end
    if (r2_load) begin
      r2_corr <= r1_corr;
      r2_abs  <= abs1;
      r2_sq   <= sq1;
      r2_last <= r1_last;
      r2_num  <= r1_num;
    end
    if (o_load) begin
      o_num   <= r2_num;
      o_corr  <= spsd_pkg::BIT_CORR_W'(r2_corr);
      o_value <= (r2_corr > 0);
      o_final <= r2_last;
      if (r2_last) begin
        o_total <= spsd_pkg::CORR_TOTAL_W'(sum_next);
        o_sq    <= spsd_pkg::SQ_TOTAL_W'(sq_next);
        o_abs   <= spsd_pkg::ABS_TOTAL_W'(abs_next);
        o_susp  <= susp_next;
      end else begin
        o_total <= '0;
        o_sq    <= '0;
        o_abs   <= '0;
        o_susp  <= 1'b0;
      end
    end
  end

  assign res.valid         = ov;
  assign res.bit_number    = o_num;
  assign res.bit_corr      = o_corr;
  assign res.bit_value     = o_value;
  assign res.final_bit     = o_final;
  assign res.corr_total    = o_total;
  assign res.corr_sq_total = o_sq;
  assign res.abs_total     = o_abs;
  assign res.suspicious    = o_susp;

  `SPSD_ASSERT(a_reseed_after_last, clk, rst, pix_fire && last0 |=> lcg_state == seed)
  `SPSD_ASSERT(a_corr_from_done, clk, rst, r1v && !$past(r1v) |-> $past(v1 && done1))
  `SPSD_ASSERT_ALWAYS(a_totals_only_final, clk, ov && !o_final |-> o_total == '0 && o_sq == '0 && o_abs == '0 && !o_susp)
  `SPSD_ASSERT_ALWAYS(a_final_number, clk, ov && o_final |-> o_num == spsd_pkg::BIT_NUM_W'(HEADER_LEN - 1))

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int CHIP_LEN   = 64;
  localparam int HEADER_LEN = 32;

  typedef struct packed {
    spsd_pkg::pix_t [3:0] a;
    spsd_pkg::pix_t [3:0] b;
  } pix_word_t;

  typedef struct {
    logic [spsd_pkg::BIT_NUM_W-1:0]           bit_number;
    logic signed [spsd_pkg::BIT_CORR_W-1:0]   bit_corr;
    logic                                     bit_value;
    logic                                     final_bit;
    logic signed [spsd_pkg::CORR_TOTAL_W-1:0] corr_total;
    logic [spsd_pkg::SQ_TOTAL_W-1:0]          corr_sq_total;
    logic [spsd_pkg::ABS_TOTAL_W-1:0]         abs_total;
    logic                                     suspicious;
  } bit_report_t;

  typedef enum {
    WORD_UNIFORM, WORD_NEAR, WORD_POS_MAX, WORD_NEG_MAX, WORD_EDGE, WORD_MIXED
  } word_style_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [spsd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [spsd_pkg::CFG_DATA_W-1:0] cfg_data;

  spsd_pix_if pix ();
  spsd_res_if res ();

  spread_spectrum_despread_detector #(
    .CHIP_LEN   (CHIP_LEN),
    .HEADER_LEN (HEADER_LEN)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .res       (res)
  );

  // register copies
  logic [spsd_pkg::LCG_W-1:0]  seed_q;
  logic [spsd_pkg::LCG_W-1:0]  mult_q;
  logic [spsd_pkg::LCG_W-1:0]  inc_q;
  logic [spsd_pkg::CHAN_W-1:0] chan_q;
  logic [spsd_pkg::POS_W-1:0]  pos_q;

  // despreader state
  logic [spsd_pkg::LCG_W-1:0] gen_state;
  int                         chip_idx;
  int                         bit_idx;
  longint                     bit_sum;
  longint                     corr_sum;
  longint                     corr_sq;
  longint                     corr_abs;
  int                         finals_predicted = 0;

  bit_report_t expected_bits[$];
  int          bad_count = 0;
  int          src_gap_pct = 12;
  int          snk_stall_pct = 10;
  bit          quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_run();
    gen_state = seed_q;
    chip_idx  = 0;
    bit_idx   = 0;
    bit_sum   = 0;
    corr_sum  = 0;
    corr_sq   = 0;
    corr_abs  = 0;
  endfunction

  function automatic void despread_step(pix_word_t w);
    int          eff;
    longint      diff;
    longint      mag;
    bit          last;
    bit_report_t r;
    eff = (chan_q == 0) ? 1 : (chan_q > spsd_pkg::MAX_CH) ? spsd_pkg::MAX_CH : int'(chan_q);
    diff = 0;
    for (int c = 0; c < eff; c++)
      diff += longint'(w.a[c]) - longint'(w.b[c]);
    gen_state = gen_state * mult_q + inc_q;
    bit_sum += gen_state[pos_q] ? diff : -diff;
    chip_idx++;
    if (chip_idx < CHIP_LEN)
      return;
    mag = (bit_sum < 0) ? -bit_sum : bit_sum;
    corr_sum += bit_sum;
    corr_sq  += mag * mag;
    corr_abs += mag;
    last = (bit_idx + 1 >= HEADER_LEN);
    r.bit_number = spsd_pkg::BIT_NUM_W'(bit_idx);
    r.bit_corr   = spsd_pkg::BIT_CORR_W'(bit_sum);
    r.bit_value  = (bit_sum > 0);
    r.final_bit  = last;
    if (last) begin
      r.corr_total    = spsd_pkg::CORR_TOTAL_W'(corr_sum);
      r.corr_sq_total = spsd_pkg::SQ_TOTAL_W'(corr_sq);
      r.abs_total     = spsd_pkg::ABS_TOTAL_W'(corr_abs);
      r.suspicious    = (2 * corr_abs > longint'(CHIP_LEN * HEADER_LEN * eff));
      finals_predicted++;
      restart_run();
    end else begin
      r.corr_total    = '0;
      r.corr_sq_total = '0;
      r.abs_total     = '0;
      r.suspicious    = 1'b0;
      chip_idx = 0;
      bit_sum  = 0;
      bit_idx++;
    end
    expected_bits.push_back(r);
  endfunction

  function automatic void note_failure(string msg);
    bad_count++;
    if (bad_count <= 10)
      $display("%s", msg);
  endfunction

  function automatic void check_field(string name, int bitno, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want)
      note_failure($sformatf("bit %0d %s: expected %0d, got %0d", bitno, name, want, got));
  endfunction

  // result checker
  always @(posedge clk) begin
    bit_report_t want;
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (expected_bits.size() == 0) begin
        note_failure("result word arrived with no expectation waiting");
      end else begin
        want = expected_bits.pop_front();
        check_field("bit_number", want.bit_number, want.bit_number, res.bit_number);
        check_field("bit_corr", want.bit_number, want.bit_corr, res.bit_corr);
        check_field("bit_value", want.bit_number, want.bit_value, res.bit_value);
        check_field("final_bit", want.bit_number, want.final_bit, res.final_bit);
        check_field("corr_total", want.bit_number, want.corr_total, res.corr_total);
        check_field("corr_sq_total", want.bit_number, want.corr_sq_total,
                    res.corr_sq_total);
        check_field("abs_total", want.bit_number, want.abs_total, res.abs_total);
        check_field("suspicious", want.bit_number, want.suspicious, res.suspicious);
      end
    end
  end

  // result receiver with stall bursts
  initial begin
    int stall;
    stall = 0;
    res.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (quiet || rst) begin
        stall = 0;
        res.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        res.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < snk_stall_pct) begin
        stall = $urandom_range(1, 19) - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  function automatic pix_word_t fill_word(spsd_pkg::pix_t av, spsd_pkg::pix_t bv);
    pix_word_t w;
    w.a = {4{av}};
    w.b = {4{bv}};
    return w;
  endfunction

  function automatic pix_word_t make_word(word_style_t style);
    pix_word_t   w;
    word_style_t pick;
    pick = style;
    if (style == WORD_MIXED)
      pick = word_style_t'($urandom_range(0, 4));
    case (pick)
      WORD_NEAR: begin
        // differences of at most one per channel keep the correlation low
        for (int c = 0; c < spsd_pkg::MAX_CH; c++) begin
          w.a[c] = spsd_pkg::pix_t'($urandom);
          w.b[c] = w.a[c] ^ spsd_pkg::pix_t'($urandom_range(0, 1));
        end
      end
      WORD_POS_MAX: w = fill_word(8'hFF, 8'h00);
      WORD_NEG_MAX: w = fill_word(8'h00, 8'hFF);
      WORD_EDGE: begin
        for (int i = 0; i < 2 * spsd_pkg::MAX_CH; i++) begin
          case ($urandom_range(0, 2))
            0:       w[i*spsd_pkg::PIX_W +: spsd_pkg::PIX_W] = 8'h00;
            1:       w[i*spsd_pkg::PIX_W +: spsd_pkg::PIX_W] = 8'hFF;
            default: w[i*spsd_pkg::PIX_W +: spsd_pkg::PIX_W] = spsd_pkg::pix_t'($urandom);
          endcase
        end
      end
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic send_word(pix_word_t w);
    int gap;
    if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
      gap = $urandom_range(1, 19);
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.a_ch0 <= w.a[0];
    pix.a_ch1 <= w.a[1];
    pix.a_ch2 <= w.a[2];
    pix.a_ch3 <= w.a[3];
    pix.b_ch0 <= w.b[0];
    pix.b_ch1 <= w.b[1];
    pix.b_ch2 <= w.b[2];
    pix.b_ch3 <= w.b[3];
    do @(posedge clk); while (pix.ready !== 1'b1);
    despread_step(w);
  endtask

  task automatic send_run(int count, word_style_t style);
    repeat (count) send_word(make_word(style));
  endtask

  task automatic drain_results();
    pix.valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
  endtask

  // words that finish no bit may still be in the pipeline
  task automatic settle_idle();
    drain_results();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [spsd_pkg::CFG_IDX_W-1:0] idx,
                           logic [spsd_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      spsd_pkg::REG_SEED: begin
        seed_q = data;
        restart_run();
      end
      spsd_pkg::REG_CHANNELS: chan_q = data[spsd_pkg::CHAN_W-1:0];
      spsd_pkg::REG_LCG_MULT: mult_q = data;
      spsd_pkg::REG_LCG_ADD:  inc_q = data;
      spsd_pkg::REG_CHIP_POS: pos_q = data[spsd_pkg::POS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // field extremes and channel patterns under the reset configuration
  task automatic test_directed();
    pix_word_t w;
    for (int k = 0; k < 16; k++) begin
      case (k)
        0:  w = fill_word(8'h00, 8'h00);
        1:  w = fill_word(8'hFF, 8'hFF);
        2:  w = fill_word(8'hFF, 8'h00);
        3:  w = fill_word(8'h00, 8'hFF);
        12: w = fill_word(8'h55, 8'hAA);
        13: w = fill_word(8'hAA, 8'h55);
        14: w = fill_word(8'h01, 8'h80);
        15: w = fill_word(8'h80, 8'h01);
        default: begin
          // one hot channel, in pixel A then pixel B
          w = fill_word(8'h00, 8'h00);
          if (k < 8)
            w.a[k-4] = 8'hFF;
          else
            w.b[k-8] = 8'hFF;
        end
      endcase
      send_word(w);
    end
  endtask

  // first bit under the reset configuration, then a partial bit left open
  task automatic test_default_header();
    send_run(CHIP_LEN - 16 + 30, WORD_UNIFORM);
    drain_results();
  endtask

  // unknown indexes, a seed write that drops the partial bit, then channel and generator changes
  task automatic test_register_decoding();
    settle_idle();
    src_gap_pct   = 12;
    snk_stall_pct = 10;
    for (int i = int'(spsd_pkg::REG_CHIP_POS) + 1; i < 2 ** spsd_pkg::CFG_IDX_W; i++)
      write_reg(i[spsd_pkg::CFG_IDX_W-1:0], $urandom);
    write_reg(spsd_pkg::REG_CHANNELS, 32'd1);
    write_reg(spsd_pkg::REG_CHIP_POS, 32'd31);
    write_reg(spsd_pkg::REG_LCG_MULT, $urandom);
    write_reg(spsd_pkg::REG_LCG_ADD, 32'd0);
    write_reg(spsd_pkg::REG_SEED, $urandom);
    send_run(CHIP_LEN * 2, WORD_UNIFORM);
    settle_idle();
    write_reg(spsd_pkg::REG_CHANNELS, 32'd5);
    write_reg(spsd_pkg::REG_LCG_ADD, spsd_pkg::LCG_ADD_RST);
    send_run(CHIP_LEN * 2, WORD_MIXED);
    settle_idle();
    write_reg(spsd_pkg::REG_CHANNELS, 32'd2);
    write_reg(spsd_pkg::REG_LCG_MULT, spsd_pkg::LCG_MULT_RST);
    send_run(CHIP_LEN * 2, WORD_MIXED);
  endtask

  // zero and oversized channel counts, junk in the upper data bits
  task automatic test_threshold_header();
    settle_idle();
    src_gap_pct   = 0;
    snk_stall_pct = 20;
    write_reg(spsd_pkg::REG_CHANNELS, 32'hFFFF_FFF8);
    write_reg(spsd_pkg::REG_LCG_MULT, 32'hFFFF_FFFF);
    write_reg(spsd_pkg::REG_LCG_ADD, $urandom | 32'd1);
    write_reg(spsd_pkg::REG_CHIP_POS, 32'hFFFF_FFE0 | $urandom_range(1, 30));
    send_run(CHIP_LEN * 2, WORD_NEAR);
    settle_idle();
    write_reg(spsd_pkg::REG_CHANNELS, 32'hFFFF_FFFF);
    send_run(CHIP_LEN * 2, WORD_NEAR);
  endtask

  // constant +1 chip and full-scale words finish the header with large totals
  task automatic test_saturated_header();
    int target;
    settle_idle();
    src_gap_pct   = 12;
    snk_stall_pct = 30;
    write_reg(spsd_pkg::REG_CHANNELS, 32'd4);
    write_reg(spsd_pkg::REG_LCG_MULT, 32'd0);
    write_reg(spsd_pkg::REG_LCG_ADD, 32'hFFFF_FFFF);
    write_reg(spsd_pkg::REG_CHIP_POS, 32'd0);
    target = finals_predicted + 1;
    while (finals_predicted < target) begin
      if (bit_idx >= HEADER_LEN - 8)
        quiet = 1'b1;
      send_run(CHIP_LEN, ($urandom_range(0, 1) != 0) ? WORD_POS_MAX : WORD_NEG_MAX);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= spsd_pkg::REG_SEED;
    cfg_data  <= '0;
    pix.valid <= 1'b0;
    pix.a_ch0 <= '0;
    pix.a_ch1 <= '0;
    pix.a_ch2 <= '0;
    pix.a_ch3 <= '0;
    pix.b_ch0 <= '0;
    pix.b_ch1 <= '0;
    pix.b_ch2 <= '0;
    pix.b_ch3 <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    seed_q = spsd_pkg::SEED_RST;
    chan_q = spsd_pkg::CHANNELS_RST;
    mult_q = spsd_pkg::LCG_MULT_RST;
    inc_q  = spsd_pkg::LCG_ADD_RST;
    pos_q  = spsd_pkg::CHIP_POS_RST;
    restart_run();

    test_directed();
    test_default_header();
    test_register_decoding();
    test_threshold_header();
    test_saturated_header();

    drain_results();
    repeat (10) @(posedge clk);
    if (bad_count == 0 && expected_bits.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/spsd_pkg.sv
rtl/core/spsd_intf.sv
rtl/core/spread_spectrum_despread_detector.sv
test/tb.sv
